### rtl/scba_pkg.sv
// Shared types, constants and helpers for the size class block allocator.
package scba_pkg;

    localparam int unsigned MapBits     = 32;
    localparam int unsigned Classes     = 6;
    localparam int unsigned RegionShift = 22;
    localparam int unsigned BlockShift  = 17;
    localparam int unsigned DefRegions  = 16;

    localparam logic [2:0] PoolClass = 3'(Classes - 1);

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_PARTIAL = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam logic [31:0] RamBaseReset = 32'h3000_0000;
    localparam logic [4:0]  CountReset   = 5'd16;

    // One region table entry
    typedef struct packed {
        logic [31:0] bitmap;
        logic [2:0]  cls;
        logic [1:0]  st;
        logic [7:0]  ord;
    } t_rgn;

    // Bitmap mask of the blocks that exist in a region of class c
    function automatic logic [31:0] class_mask(input logic [2:0] c);
        logic [31:0] m;
        m = '0;
        for (int k = 0; k < 32; k++) begin
            m[k] = (k < (32 >> c));
        end
        return m;
    endfunction

    // Lowest clear bit below the class bit count; bit 5 flags a hit
    function automatic logic [5:0] lowest_clear(input logic [31:0] bmp,
                                                input logic [2:0] c);
        logic [31:0] m;
        logic [5:0]  res;
        m   = class_mask(c);
        res = '0;
        for (int k = 31; k >= 0; k--) begin
            if (m[k] && !bmp[k]) begin
                res = {1'b1, 5'(k)};
            end
        end
        return res;
    endfunction

endpackage

### rtl/size_class_block_allocator_unit.sv
// Top level: APB registers, request sequencer and shared compare unit.
//
// Usage: raise start with mode, size class and free address while busy is
// low; the transaction is taken at that edge and busy rises. When the work
// ends, o_done pulses for one cycle with o_status and o_block_address.
// The receiver cannot stall, so the result must be taken in that cycle.
// Sequence: an allocate scans the region table for the partial queue head,
// then the empty pool head if needed, picks the bit, sweeps the table to
// relink queues and writes the moved region, then enters the done state.
// A free checks its entry, and when the region empties sweeps the table
// and writes the moved region. One table entry passes the compare unit
// per cycle. A new transaction is taken the cycle after o_done.
// Reset puts region 0 in class 0 with block 0 taken, all other regions in
// the empty pool, ram_base at 0x30000000 and region_count at 16.
// Registers: ram_base at byte 0, region_count at byte 4 (APB, pready high).
module size_class_block_allocator_unit #(
    parameter int unsigned REGIONS = scba_pkg::DefRegions
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [2:0]  i_size_class,
    input  logic [31:0] i_free_address,
    output logic        o_done,
    output logic        o_status,
    output logic [31:0] o_block_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scba_pkg::*;

    localparam int unsigned AW = $clog2(REGIONS);
    localparam int unsigned NW = $clog2(REGIONS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCANP = 3'd2;
    localparam logic [2:0] S_SCANE = 3'd3;
    localparam logic [2:0] S_PICK  = 3'd4;
    localparam logic [2:0] S_SWEEP = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [31:0]   r_base;
    logic [4:0]    r_count;
    logic [2:0]    r_state, n_state;
    logic          r_mode, n_mode;
    logic [2:0]    r_cls, n_cls;
    logic [31:0]   r_addr, n_addr;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_sel, n_sel;
    logic          r_found, n_found;
    logic [7:0]    r_bord, n_bord;
    logic [2:0]    r_oc, n_oc;
    logic [1:0]    r_os, n_os;
    logic [7:0]    r_oo, n_oo;
    logic [1:0]    r_ns, n_ns;
    logic          r_topf, n_topf;
    logic [7:0]    r_top, n_top;
    logic          r_push, n_push;
    logic          r_status, n_status;
    logic [31:0]   r_baddr, n_baddr;

    logic [NW-1:0] w_n;
    logic          w_last;
    logic [AW-1:0] w_rd_idx;
    t_rgn          w_rd, w_wr;
    logic          w_we;
    logic [AW-1:0] w_wr_idx;
    logic [31:0]   w_off;
    logic [4:0]    w_fbit;
    logic [5:0]    w_lc;
    logic [7:0]    w_o1;
    logic          w_hit;

    // Configuration registers
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COUNT) ? {27'd0, r_count} : r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RamBaseReset;
            r_count <= CountReset;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_BASE) begin
                r_base <= pwdata;
            end else begin
                r_count <= pwdata[4:0];
            end
        end
    end

    // Clamp the region count to between one and the table size
    always_comb begin
        if (r_count == 5'd0) begin
            w_n = NW'(1);
        end else if (32'(r_count) > REGIONS) begin
            w_n = NW'(REGIONS);
        end else begin
            w_n = NW'(r_count);
        end
    end

    assign w_last = ((NW'(r_idx) + NW'(1)) == w_n);
    assign w_off  = r_addr - r_base;
    assign w_fbit = 5'(w_off[RegionShift-1:0] >> (BlockShift + 32'(r_cls)));

    // Choose the table entry the compare unit sees
    always_comb begin
        case (r_state)
            S_CHECK:       w_rd_idx = w_off[RegionShift +: AW];
            S_PICK, S_FIN: w_rd_idx = r_sel;
            default:       w_rd_idx = r_idx;
        endcase
    end

    scba_rgn_file #(.REGIONS(REGIONS), .AW(AW)) u_tab (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (w_rd_idx),
        .o_rd     (w_rd),
        .i_we     (w_we),
        .i_wr_idx (w_wr_idx),
        .i_wr     (w_wr)
    );

    assign w_lc = lowest_clear(w_rd.bitmap, r_cls);
    assign w_o1 = (w_rd.cls == r_oc && w_rd.st == r_os && w_rd.ord > r_oo)
                  ? w_rd.ord - 8'd1 : w_rd.ord;

    // Sequence one transaction
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_cls    = r_cls;
        n_addr   = r_addr;
        n_idx    = r_idx;
        n_sel    = r_sel;
        n_found  = r_found;
        n_bord   = r_bord;
        n_oc     = r_oc;
        n_os     = r_os;
        n_oo     = r_oo;
        n_ns     = r_ns;
        n_topf   = r_topf;
        n_top    = r_top;
        n_push   = r_push;
        n_status = r_status;
        n_baddr  = r_baddr;
        w_we     = 1'b0;
        w_wr_idx = w_rd_idx;
        w_wr     = w_rd;
        w_hit    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode   = i_mode;
                    n_cls    = i_size_class;
                    n_addr   = i_free_address;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_status = STATUS_FAIL;
                    n_baddr  = '0;
                    if (32'(i_size_class) >= Classes) begin
                        n_state = S_DONE;
                    end else if (i_mode == MODE_FREE) begin
                        n_state = S_CHECK;
                    end else begin
                        n_state = S_SCANP;
                    end
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                if (r_addr != 32'd0 && w_off[31:RegionShift] < 10'(w_n) &&
                    w_rd.cls == r_cls &&
                    (w_rd.st == ST_PARTIAL || w_rd.st == ST_FULL) &&
                    w_rd.bitmap[w_fbit]) begin
                    n_status = STATUS_OK;
                    w_we = 1'b1;
                    w_wr.bitmap[w_fbit] = 1'b0;
                    if ((w_wr.bitmap & class_mask(r_cls)) == 32'd0) begin
                        n_sel   = w_rd_idx;
                        n_oc    = w_rd.cls;
                        n_os    = w_rd.st;
                        n_oo    = w_rd.ord;
                        n_push  = 1'b1;
                        n_idx   = '0;
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SCANP, S_SCANE: begin
                // Track the queue head: lowest order, lower index on ties
                if (r_state == S_SCANP) begin
                    w_hit = (w_rd.cls == r_cls && w_rd.st == ST_PARTIAL);
                end else begin
                    w_hit = (w_rd.cls == PoolClass && w_rd.st == ST_EMPTY);
                end
                if (w_hit && (!r_found || w_rd.ord < r_bord)) begin
                    n_found = 1'b1;
                    n_bord  = w_rd.ord;
                    n_sel   = r_idx;
                end
                n_idx = r_idx + AW'(1);
                if (w_last) begin
                    n_idx = '0;
                    if (n_found) begin
                        n_state = S_PICK;
                    end else if (r_state == S_SCANP) begin
                        n_state = S_SCANE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PICK: begin
                if (!w_lc[5]) begin
                    n_state = S_DONE;
                end else begin
                    w_we = 1'b1;
                    w_wr.bitmap[w_lc[4:0]] = 1'b1;
                    n_oc   = w_rd.cls;
                    n_os   = w_rd.st;
                    n_oo   = w_rd.ord;
                    n_ns   = ((w_wr.bitmap & class_mask(r_cls)) == class_mask(r_cls))
                             ? ST_FULL : ST_PARTIAL;
                    n_push = 1'b0;
                    n_topf = 1'b0;
                    n_idx  = '0;
                    n_status = STATUS_OK;
                    n_baddr  = r_base + (32'(r_sel) << RegionShift) +
                               (32'(w_lc[4:0]) << (BlockShift + 32'(r_cls)));
                    n_state  = S_SWEEP;
                end
            end
            S_SWEEP: begin
                // Relink every other present region in one pass
                if (r_idx != r_sel) begin
                    w_we = 1'b1;
                    w_wr.ord = w_o1;
                    if (r_push) begin
                        if (w_rd.cls == PoolClass && w_rd.st == ST_EMPTY &&
                            w_o1 != 8'hFF) begin
                            w_wr.ord = w_o1 + 8'd1;
                        end
                    end else if (w_rd.cls == r_cls && w_rd.st == r_ns &&
                                 (!r_topf || w_o1 > r_top)) begin
                        n_topf = 1'b1;
                        n_top  = w_o1;
                    end
                end
                n_idx = r_idx + AW'(1);
                if (w_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Place the moved region at its queue end or pool front
                w_we = 1'b1;
                if (r_push) begin
                    w_wr.cls = PoolClass;
                    w_wr.st  = ST_EMPTY;
                    w_wr.ord = 8'd0;
                end else begin
                    w_wr.cls = r_cls;
                    w_wr.st  = r_ns;
                    w_wr.ord = !r_topf ? 8'd0 :
                               (r_top == 8'hFF ? 8'hFF : r_top + 8'd1);
                end
                n_state = S_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold payload and work registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_cls    <= n_cls;
        r_addr   <= n_addr;
        r_idx    <= n_idx;
        r_sel    <= n_sel;
        r_found  <= n_found;
        r_bord   <= n_bord;
        r_oc     <= n_oc;
        r_os     <= n_os;
        r_oo     <= n_oo;
        r_ns     <= n_ns;
        r_topf   <= n_topf;
        r_top    <= n_top;
        r_push   <= n_push;
        r_status <= n_status;
        r_baddr  <= n_baddr;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = (r_state == S_DONE);
    assign o_status        = r_status;
    assign o_block_address = r_baddr;

    // Free transactions never report an address
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && r_mode == MODE_FREE |-> o_block_address == 32'd0)
        else $error("free returned an address");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == STATUS_FAIL |-> o_block_address == 32'd0)
        else $error("failed transaction returned an address");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block stayed busy after done");

endmodule

### rtl/scba_rgn_file.sv
// Region table: one combinational read port and one write port.
module scba_rgn_file #(
    parameter int unsigned REGIONS = scba_pkg::DefRegions,
    parameter int unsigned AW      = $clog2(REGIONS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [AW-1:0]     i_rd_idx,
    output scba_pkg::t_rgn    o_rd,
    input  logic              i_we,
    input  logic [AW-1:0]     i_wr_idx,
    input  scba_pkg::t_rgn    i_wr
);
    import scba_pkg::*;

    t_rgn r_tab [REGIONS];

    // Read the selected entry
    assign o_rd = r_tab[i_rd_idx];

    // Load reset contents, then take writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REGIONS; i++) begin
                r_tab[i].bitmap <= (i == 0) ? 32'd1 : 32'd0;
                r_tab[i].cls    <= (i == 0) ? 3'd0 : PoolClass;
                r_tab[i].st     <= (i == 0) ? ST_PARTIAL : ST_EMPTY;
                r_tab[i].ord    <= 8'(i);
            end
        end else if (i_we) begin
            r_tab[i_wr_idx] <= i_wr;
        end
    end

endmodule

### tb/tb_top.sv
// Self-checking testbench for the size class block allocator unit.
`timescale 1ns / 100ps

module tb_top;
    import scba_pkg::*;

    localparam int NREG = 16;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic        mode;
        logic [2:0]  cls;
        logic [31:0] addr;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [31:0] baddr;
    } t_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_mode = 1'b0;
    logic [2:0]  i_size_class = '0;
    logic [31:0] i_free_address = '0;
    logic        o_done;
    logic        o_status;
    logic [31:0] o_block_address;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    size_class_block_allocator_unit #(.REGIONS(NREG)) DUT (.*);

    always #6 i_clk = ~i_clk;

    // Allocator shadow state
    logic [31:0] m_base;
    logic [4:0]  m_count;
    logic [31:0] m_bmp [NREG];
    logic [2:0]  m_cls [NREG];
    logic [1:0]  m_st  [NREG];
    logic [7:0]  m_ord [NREG];

    t_req  pending_reqs[$];
    t_resp expected_resps[$];
    logic [31:0] live_blocks[$];
    int    mismatches = 0;
    int    cycles = 0;
    bit    quiet = 1'b0;
    bit    hold_send = 1'b0;
    int    gap = 0;

    function automatic int n_present();
        int n;
        n = m_count;
        if (n < 1) n = 1;
        if (n > NREG) n = NREG;
        return n;
    endfunction

    function automatic logic [31:0] mask_of(input logic [2:0] c);
        int bits;
        bits = 32 >> c;
        return (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
    endfunction

    function automatic int head_of(input logic [2:0] c, input logic [1:0] s);
        int best;
        best = -1;
        for (int i = 0; i < n_present(); i++)
            if (m_cls[i] == c && m_st[i] == s && (best < 0 || m_ord[i] < m_ord[best]))
                best = i;
        return best;
    endfunction

    function automatic void unlink(input int r);
        for (int i = 0; i < n_present(); i++)
            if (i != r && m_cls[i] == m_cls[r] && m_st[i] == m_st[r] && m_ord[i] > m_ord[r])
                m_ord[i]--;
    endfunction

    function automatic void shadow_reset();
        m_base = RamBaseReset;
        m_count = CountReset;
        for (int i = 0; i < NREG; i++) begin
            m_bmp[i] = '0;
            m_cls[i] = PoolClass;
            m_st[i]  = ST_EMPTY;
            m_ord[i] = 8'(i);
        end
        m_bmp[0] = 32'd1;
        m_cls[0] = 3'd0;
        m_st[0]  = ST_PARTIAL;
    endfunction

    // Compute the response of one request and update the shadow state
    function automatic t_resp allocate_or_free(input t_req q);
        t_resp rs;
        int r, b, bits, top;
        logic [31:0] off, bit_i;
        logic [1:0] ns;
        rs.status = STATUS_FAIL;
        rs.baddr = '0;
        if (q.cls >= 3'(Classes)) return rs;
        if (q.mode == MODE_ALLOC) begin
            bits = 32 >> q.cls;
            r = head_of(q.cls, ST_PARTIAL);
            if (r < 0) r = head_of(PoolClass, ST_EMPTY);
            if (r < 0) return rs;
            for (b = 0; b < bits; b++)
                if (!m_bmp[r][b]) break;
            if (b >= bits) return rs;
            m_bmp[r][b] = 1'b1;
            unlink(r);
            ns = ((m_bmp[r] & mask_of(q.cls)) == mask_of(q.cls)) ? ST_FULL : ST_PARTIAL;
            top = -1;
            for (int i = 0; i < n_present(); i++)
                if (i != r && m_cls[i] == q.cls && m_st[i] == ns && int'(m_ord[i]) > top)
                    top = m_ord[i];
            m_cls[r] = q.cls;
            m_st[r]  = ns;
            m_ord[r] = (top < 255) ? 8'(top + 1) : 8'd255;
            rs.status = STATUS_OK;
            rs.baddr = m_base + (32'(r) << RegionShift) +
                       (32'(b) << (BlockShift + q.cls));
            return rs;
        end
        if (q.addr == 0) return rs;
        off = q.addr - m_base;
        if ((off >> RegionShift) >= 32'(n_present())) return rs;
        r = int'(off >> RegionShift);
        if (m_cls[r] != q.cls) return rs;
        if (m_st[r] != ST_PARTIAL && m_st[r] != ST_FULL) return rs;
        bit_i = (off & 32'h3F_FFFF) >> (BlockShift + q.cls);
        if (bit_i >= 32 || !m_bmp[r][bit_i[4:0]]) return rs;
        m_bmp[r][bit_i[4:0]] = 1'b0;
        if ((m_bmp[r] & mask_of(q.cls)) == 0) begin
            unlink(r);
            for (int i = 0; i < n_present(); i++)
                if (i != r && m_cls[i] == PoolClass && m_st[i] == ST_EMPTY && m_ord[i] < 255)
                    m_ord[i]++;
            m_cls[r] = PoolClass;
            m_st[r]  = ST_EMPTY;
            m_ord[r] = 8'd0;
        end
        rs.status = STATUS_OK;
        return rs;
    endfunction

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("size_class_block_allocator_unit regression: fail");
            $finish;
        end
    end

    // Driver: present the next request at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_send) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (gap > 0) begin
            gap <= gap - 1;
            start <= 1'b0;
        end else if (!busy && pending_reqs.size() > 0 && !(start && !busy)) begin
            t_req q;
            q = pending_reqs.pop_front();
            expected_resps.push_back(allocate_or_free(q));
            i_mode <= q.mode;
            i_size_class <= q.cls;
            i_free_address <= q.addr;
            start <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 18);
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: check each strobed response against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_resps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %0b %h", o_status, o_block_address);
            end else begin
                t_resp e;
                e = expected_resps.pop_front();
                if (e.status != o_status || e.baddr != o_block_address) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0b %h got %0b %h",
                                 e.status, e.baddr, o_status, o_block_address);
                end else if (e.status == STATUS_OK && e.baddr != 0) begin
                    live_blocks.push_back(e.baddr);
                end
            end
        end
    end

    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Wait for all responses plus the worst allocate latency
    task automatic drain();
        while (pending_reqs.size() > 0 || expected_resps.size() > 0 || start)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] base, input logic [4:0] cnt);
        apb_write({REG_BASE, 2'b00}, base);
        m_base = base;
        apb_write({REG_COUNT, 2'b00}, 32'(cnt));
        m_count = cnt;
    endtask

    task automatic push(input logic m, input logic [2:0] c, input logic [31:0] a);
        t_req q;
        q.mode = m; q.cls = c; q.addr = a;
        pending_reqs.push_back(q);
    endtask

    // Mostly well-formed allocate/free traffic, some noise
    task automatic random_phase(input int n);
        int k;
        logic [31:0] a;
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(0, 19);
            if (k < 9) begin
                push(MODE_ALLOC, 3'($urandom_range(0, 5)), $urandom);
            end else if (k < 16 && live_blocks.size() > 0) begin
                int p;
                p = $urandom_range(0, live_blocks.size() - 1);
                a = live_blocks[p];
                live_blocks.delete(p);
                // frees carry a random class and sometimes a random offset inside the block
                push(MODE_FREE, 3'($urandom_range(0, 5)),
                     a | ($urandom_range(0, 1) ? ($urandom & 32'h1FFFF) : 32'd0));
            end else if (k < 18) begin
                push(MODE_FREE, 3'($urandom_range(0, 5)),
                     m_base + ($urandom_range(0, 17) << RegionShift) +
                     ($urandom_range(0, 31) << BlockShift));
            end else begin
                push(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom);
            end
            if (pending_reqs.size() > 8) @(posedge i_clk);
            while (pending_reqs.size() > 4) @(posedge i_clk);
        end
    endtask

    initial begin
        shadow_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, invalid class, zero address, bad frees
        push(MODE_ALLOC, 3'd0, 32'h0);
        push(MODE_ALLOC, 3'd5, 32'hFFFF_FFFF);
        push(MODE_ALLOC, 3'd6, 32'h0);
        push(MODE_FREE, 3'd7, 32'h3000_0000);
        push(MODE_FREE, 3'd0, 32'h0);
        push(MODE_FREE, 3'd0, 32'hFFFF_FFFF);
        push(MODE_FREE, 3'd0, 32'h3002_0000);
        push(MODE_FREE, 3'd0, 32'h3002_0000);
        push(MODE_FREE, 3'd0, 32'h3000_0005);
        push(MODE_FREE, 3'd3, 32'h3040_0000);
        push(MODE_FREE, 3'd5, 32'h3040_0000);
        push(MODE_FREE, 3'd5, 32'h3440_0000);
        for (int j = 0; j < 6; j++) push(MODE_ALLOC, 3'(j), 32'h0);
        drain();

        // Pause until all done, then tiny memory to hit no-room
        hold_send = 1'b1;
        drain();
        hold_send = 1'b0;
        set_config(32'h0000_0000, 5'd0);
        for (int j = 0; j < 6; j++) push(MODE_ALLOC, 3'd5, 32'h0);
        drain();

        set_config(32'hFFC0_0000, 5'd31);
        random_phase(400);
        drain();
        set_config(32'h1240_0000, 5'd3);
        random_phase(400);
        drain();
        set_config(32'hFFFF_FFFF, 5'd1);
        random_phase(200);
        drain();
        set_config(32'h8000_0000, 5'd16);
        random_phase(500);
        quiet = 1'b1;
        random_phase(200);
        drain();

        if (mismatches == 0) begin
            $display("size_class_block_allocator_unit regression: pass");
        end else begin
            $display("size_class_block_allocator_unit regression: fail");
        end
        $finish;
    end

endmodule
